/* design/assert_macros.svh */
// Assertion macros used by parallel_drive_port_command_fsm.
// No dependencies; included by each module that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

// Checked only while reset is low.
`define ASSERT_ACTIVE(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

/* design/pdp_cmd_pkg.sv */
// Types and constants of the parallel drive port command block.
// No dependencies; used by parallel_drive_port_command_fsm.
`timescale 1ns / 1ps

package pdp_cmd_pkg;

   // Port register offsets.
   localparam logic [2:0] REG_DATA       = 3'd0;
   localparam logic [2:0] REG_STATUS     = 3'd1;
   localparam logic [2:0] REG_HANDSHAKE  = 3'd2;
   localparam logic [2:0] REG_DATA_DIR   = 3'd3;
   localparam logic [2:0] REG_STATUS_DIR = 3'd4;
   localparam logic [2:0] REG_HS_DIR     = 3'd5;

   // Drive command codes.
   localparam logic [3:0] CMD_NONE       = 4'd0;
   localparam logic [3:0] CMD_TALK       = 4'd1;
   localparam logic [3:0] CMD_LISTEN     = 4'd2;
   localparam logic [3:0] CMD_UNLISTEN   = 4'd3;
   localparam logic [3:0] CMD_UNTALK     = 4'd4;
   localparam logic [3:0] CMD_SEC_TALK   = 4'd5;
   localparam logic [3:0] CMD_SEC_LISTEN = 4'd6;
   localparam logic [3:0] CMD_BYTE_OUT   = 4'd7;
   localparam logic [3:0] CMD_FETCH      = 4'd8;

   // Bytes the CPU writes to the data register, and handshake bit masks.
   localparam logic [7:0] BYTE_CMD_MODE  = 8'h81;
   localparam logic [7:0] BYTE_DATA_OUT  = 8'h83;
   localparam logic [7:0] BYTE_FETCH     = 8'h84;
   localparam logic [7:0] BYTE_TALK      = 8'h40;
   localparam logic [7:0] BYTE_LISTEN    = 8'h20;
   localparam logic [7:0] BYTE_UNLISTEN  = 8'h3f;
   localparam logic [7:0] BYTE_UNTALK    = 8'h5f;
   localparam logic [7:0] BYTE_SECONDARY = 8'h82;
   localparam logic [7:0] ACK_BIT        = 8'h80;
   localparam logic [7:0] VALID_DIR_BIT  = 8'h40;

   // Status value read while the drive reports end of data.
   localparam logic [1:0] STATUS_EOI     = 2'd3;

   typedef enum logic [6:0] {
      MODE_IDLE       = 7'b0000001,
      MODE_GET_MODE   = 7'b0000010,
      MODE_TALK       = 7'b0000100,
      MODE_LISTEN     = 7'b0001000,
      MODE_SEC_TALK   = 7'b0010000,
      MODE_SEC_LISTEN = 7'b0100000,
      MODE_DATA_OUT   = 7'b1000000
   } mode_type;

   typedef struct packed {
      logic [2:0] reg_offset;
      logic       drive_select;
      logic [7:0] write_data;
      logic       drive_ready;
      logic [7:0] drive_byte;
      logic       drive_eoi;
   } req_type;

   typedef struct packed {
      logic [7:0] return_value;
      logic [3:0] command;
      logic [7:0] command_byte;
      logic       init_request;
      logic       handshake_write;
      logic [7:0] handshake_value;
      logic       data_write;
      logic [7:0] data_value;
      logic       status_write;
      logic [1:0] status_value;
      logic       status_clear_all;
   } rsp_type;

endpackage

/* design/parallel_drive_port_command_fsm.sv */
// Command decoder and handshake model of a two-drive parallel disk port.
// Depends on pdp_cmd_pkg and assert_macros.svh.
`timescale 1ns / 1ps

// Channel   Ports                               Direction  Moves
// req       req_valid, req_stall, req_data      in         one CPU write with drive replies
// rsp       rsp_valid, rsp_stall, rsp_data      out        one result per write
// csr       csr_valid, csr_ready, csr_data      in         bus_enabled register
//
// Each item is held in the input register and is decoded into the result
// register when the result register is free.
// A new item is taken every cycle while req_stall is low; the decode and
// mode update are the only logic between the two registers.
// Reset clears the mode, the flags, the drive state and both valid bits,
// and sets bus_enabled.
// A stall on rsp holds the result; the input register then fills and req_stall rises.

`include "assert_macros.svh"

module parallel_drive_port_command_fsm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pdp_cmd_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pdp_cmd_pkg::rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_data
);

   // Pipeline registers.
   logic                 in_valid_ff;
   pdp_cmd_pkg::req_type in_data_ff;
   logic                 out_valid_ff;
   pdp_cmd_pkg::rsp_type out_data_ff;
   pdp_cmd_pkg::rsp_type out_data_in;

   // Port state.
   logic                 bus_enabled_ff;
   pdp_cmd_pkg::mode_type mode_ff, mode_in;
   logic                 no_flip_ff, no_flip_in;
   logic                 data_dir_ff, data_dir_in;
   logic                 status_dir_ff, status_dir_in;
   logic                 valid_dir_ff, valid_dir_in;
   logic                 ack_dir_ff, ack_dir_in;
   logic                 inited_ff [2];
   logic                 inited_in [2];
   logic [7:0]           hs_ff [2];
   logic [7:0]           hs_in [2];
   logic [7:0]           next_byte_ff, next_byte_in;

   // The result register is free when empty or being taken this cycle.
   logic out_free;
   logic advance;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign csr_ready = 1'b1;

   // Decode of the write held in the input register.
   always_comb begin
      logic       d;
      logic       attempt;
      logic       inited_now;
      logic       ok;
      logic [1:0] st;
      logic [7:0] wd;
      logic [7:0] flipped;

      d          = !in_data_ff.drive_select;
      wd         = in_data_ff.write_data;
      st         = in_data_ff.drive_eoi ? pdp_cmd_pkg::STATUS_EOI : 2'd0;
      ok         = 1'b0;
      flipped    = wd ^ pdp_cmd_pkg::ACK_BIT;

      out_data_in   = '0;
      mode_in       = mode_ff;
      no_flip_in    = no_flip_ff;
      data_dir_in   = data_dir_ff;
      status_dir_in = status_dir_ff;
      valid_dir_in  = valid_dir_ff;
      ack_dir_in    = ack_dir_ff;
      inited_in     = inited_ff;
      hs_in         = hs_ff;
      next_byte_in  = next_byte_ff;

      // A drive that has not come up yet is initialized first.
      attempt = !inited_ff[d] && bus_enabled_ff;
      if (attempt) begin
         out_data_in.init_request = 1'b1;
         no_flip_in = 1'b0;
         if (in_data_ff.drive_ready) begin
            out_data_in.status_clear_all = 1'b1;
            inited_in[d] = 1'b1;
         end
      end
      inited_now = inited_ff[d] || (attempt && in_data_ff.drive_ready);

      if (inited_now) begin
         case (in_data_ff.reg_offset)
            pdp_cmd_pkg::REG_DATA: begin
               no_flip_in = 1'b0;
               out_data_in.return_value = wd;
               unique case (mode_ff)
                  pdp_cmd_pkg::MODE_GET_MODE: begin
                     if (data_dir_ff) begin
                        if (wd == pdp_cmd_pkg::BYTE_TALK) begin
                           mode_in = pdp_cmd_pkg::MODE_TALK;
                           out_data_in.command = pdp_cmd_pkg::CMD_TALK;
                           ok = 1'b1;
                        end else if (wd == pdp_cmd_pkg::BYTE_LISTEN) begin
                           mode_in = pdp_cmd_pkg::MODE_LISTEN;
                           out_data_in.command = pdp_cmd_pkg::CMD_LISTEN;
                           ok = 1'b1;
                        end else if (wd == pdp_cmd_pkg::BYTE_UNLISTEN) begin
                           mode_in = pdp_cmd_pkg::MODE_IDLE;
                           out_data_in.command = pdp_cmd_pkg::CMD_UNLISTEN;
                           ok = 1'b1;
                        end else if (wd == pdp_cmd_pkg::BYTE_UNTALK) begin
                           mode_in = pdp_cmd_pkg::MODE_IDLE;
                           out_data_in.command = pdp_cmd_pkg::CMD_UNTALK;
                           ok = 1'b1;
                        end
                     end
                  end
                  pdp_cmd_pkg::MODE_TALK: begin
                     if (wd == pdp_cmd_pkg::BYTE_SECONDARY && data_dir_ff) begin
                        mode_in = pdp_cmd_pkg::MODE_SEC_TALK;
                        ok = 1'b1;
                     end
                  end
                  pdp_cmd_pkg::MODE_LISTEN: begin
                     if (wd == pdp_cmd_pkg::BYTE_SECONDARY && data_dir_ff) begin
                        mode_in = pdp_cmd_pkg::MODE_SEC_LISTEN;
                        ok = 1'b1;
                     end
                  end
                  pdp_cmd_pkg::MODE_SEC_TALK: begin
                     if (data_dir_ff) begin
                        out_data_in.command      = pdp_cmd_pkg::CMD_SEC_TALK;
                        out_data_in.command_byte = wd;
                        mode_in = pdp_cmd_pkg::MODE_IDLE;
                        ok = 1'b1;
                     end
                  end
                  pdp_cmd_pkg::MODE_SEC_LISTEN: begin
                     if (data_dir_ff) begin
                        out_data_in.command      = pdp_cmd_pkg::CMD_SEC_LISTEN;
                        out_data_in.command_byte = wd;
                        mode_in = pdp_cmd_pkg::MODE_IDLE;
                        ok = 1'b1;
                     end
                  end
                  pdp_cmd_pkg::MODE_DATA_OUT: begin
                     // Data-out mode always falls back to idle after one byte.
                     if (data_dir_ff) begin
                        out_data_in.command      = pdp_cmd_pkg::CMD_BYTE_OUT;
                        out_data_in.command_byte = wd;
                        ok = 1'b1;
                     end
                     mode_in = pdp_cmd_pkg::MODE_IDLE;
                  end
                  default: begin
                     // Idle: look for the mode-opening bytes.
                     mode_in = pdp_cmd_pkg::MODE_IDLE;
                     if (wd == pdp_cmd_pkg::BYTE_CMD_MODE) begin
                        if (data_dir_ff) begin
                           mode_in    = pdp_cmd_pkg::MODE_GET_MODE;
                           no_flip_in = 1'b1;
                           ok = 1'b1;
                        end
                     end else if (wd == pdp_cmd_pkg::BYTE_DATA_OUT) begin
                        mode_in = pdp_cmd_pkg::MODE_DATA_OUT;
                        ok = 1'b1;
                     end else if (wd == pdp_cmd_pkg::BYTE_FETCH) begin
                        next_byte_in = in_data_ff.drive_byte;
                        out_data_in.command = pdp_cmd_pkg::CMD_FETCH;
                        ok = 1'b1;
                     end
                  end
               endcase
               // An accepted byte is acknowledged by toggling handshake bit 7.
               if (ok) begin
                  hs_in[d] = hs_ff[d] ^ pdp_cmd_pkg::ACK_BIT;
                  out_data_in.handshake_write = 1'b1;
                  out_data_in.handshake_value = hs_ff[d] ^ pdp_cmd_pkg::ACK_BIT;
               end
            end
            pdp_cmd_pkg::REG_STATUS: begin
               if (!status_dir_ff) begin
                  out_data_in.return_value = {6'd0, st};
               end
            end
            pdp_cmd_pkg::REG_HANDSHAKE: begin
               if (valid_dir_ff && !no_flip_in) begin
                  hs_in[d] = flipped;
                  out_data_in.return_value    = flipped;
                  out_data_in.handshake_write = 1'b1;
                  out_data_in.handshake_value = flipped;
               end
               no_flip_in = 1'b0;
            end
            pdp_cmd_pkg::REG_DATA_DIR: begin
               data_dir_in = (wd != 8'd0);
               out_data_in.data_write = 1'b1;
               out_data_in.data_value = next_byte_ff;
            end
            pdp_cmd_pkg::REG_STATUS_DIR: begin
               status_dir_in = (wd[1:0] != 2'd0);
            end
            pdp_cmd_pkg::REG_HS_DIR: begin
               valid_dir_in = ((wd & pdp_cmd_pkg::VALID_DIR_BIT) != 8'd0);
               ack_dir_in   = ((wd & pdp_cmd_pkg::ACK_BIT) != 8'd0);
            end
            default: begin
            end
         endcase
         // The status register follows the drive whenever it is an input and the drive is up.
         if (!status_dir_in) begin
            out_data_in.status_write = 1'b1;
            out_data_in.status_value = st;
         end
      end
   end

   // Valid bits and port state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         bus_enabled_ff <= 1'b1;
         mode_ff        <= pdp_cmd_pkg::MODE_IDLE;
         no_flip_ff     <= 1'b0;
         data_dir_ff    <= 1'b0;
         status_dir_ff  <= 1'b0;
         valid_dir_ff   <= 1'b0;
         ack_dir_ff     <= 1'b0;
         inited_ff[0]   <= 1'b0;
         inited_ff[1]   <= 1'b0;
         hs_ff[0]       <= 8'd0;
         hs_ff[1]       <= 8'd0;
         next_byte_ff   <= 8'd0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (csr_valid && csr_ready) begin
            bus_enabled_ff <= csr_data;
         end
         if (advance) begin
            mode_ff       <= mode_in;
            no_flip_ff    <= no_flip_in;
            data_dir_ff   <= data_dir_in;
            status_dir_ff <= status_dir_in;
            valid_dir_ff  <= valid_dir_in;
            ack_dir_ff    <= ack_dir_in;
            inited_ff     <= inited_in;
            hs_ff         <= hs_in;
            next_byte_ff  <= next_byte_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // Drive 0, once up, stays up until reset.
   `ASSERT_ACTIVE(a_inited_sticky, inited_ff[0] |=> inited_ff[0], "drive 0 lost its init flag")

   // Every drive command is acknowledged by a handshake write.
   `ASSERT_ACTIVE(a_cmd_acked,
      out_valid_ff && (out_data_ff.command != pdp_cmd_pkg::CMD_NONE)
         |-> out_data_ff.handshake_write,
      "command issued without handshake acknowledge")

   // Status registers are only cleared by an init that was attempted.
   `ASSERT_ACTIVE(a_clear_needs_init,
      out_valid_ff && out_data_ff.status_clear_all |-> out_data_ff.init_request,
      "status clear without init attempt")

   // Reset always returns the command mode to idle.
   `ASSERT_ALWAYS(a_reset_idle, reset |=> mode_ff == pdp_cmd_pkg::MODE_IDLE,
      "mode not idle after reset")

endmodule

/* dv/pdp_cmd_checker.sv */
// Result checker for the parallel drive port command block.
// Depends on pdp_cmd_pkg; watches the req, rsp and csr channels of the block.
`timescale 1ns / 1ps

module pdp_cmd_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  pdp_cmd_pkg::req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  pdp_cmd_pkg::rsp_type rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic                 csr_data,
   output int                   fail_count,
   output int                   pending_count
);

   // Shadow copy of the port state.
   logic                  bus_en;
   pdp_cmd_pkg::mode_type cmd_mode;
   logic                  no_flip;
   logic                  data_out;
   logic                  status_out;
   logic                  valid_out;
   logic                  ack_out;
   logic                  drive_up [2];
   logic [7:0]            hs_reg [2];
   logic [7:0]            fetched;

   pdp_cmd_pkg::rsp_type expected_results [$];

   function automatic pdp_cmd_pkg::rsp_type predict_port_write(
      input pdp_cmd_pkg::req_type w);
      pdp_cmd_pkg::rsp_type r;
      logic                 d;
      logic [1:0]           st;
      logic [7:0]           wd;
      logic                 ok;
      r  = '0;
      ok = 1'b0;
      d  = !w.drive_select;
      st = w.drive_eoi ? pdp_cmd_pkg::STATUS_EOI : 2'd0;
      wd = w.write_data;
      if (!drive_up[d] && bus_en) begin
         r.init_request = 1'b1;
         no_flip = 1'b0;
         if (w.drive_ready) begin
            r.status_clear_all = 1'b1;
            drive_up[d] = 1'b1;
         end
      end
      if (drive_up[d]) begin
         if (w.reg_offset == pdp_cmd_pkg::REG_DATA) no_flip = 1'b0;
         case (w.reg_offset)
            pdp_cmd_pkg::REG_DATA: begin
               r.return_value = wd;
               case (cmd_mode)
                  pdp_cmd_pkg::MODE_GET_MODE: begin
                     if (data_out) begin
                        if (wd == pdp_cmd_pkg::BYTE_TALK) begin
                           cmd_mode = pdp_cmd_pkg::MODE_TALK;
                           r.command = pdp_cmd_pkg::CMD_TALK; ok = 1'b1;
                        end else if (wd == pdp_cmd_pkg::BYTE_LISTEN) begin
                           cmd_mode = pdp_cmd_pkg::MODE_LISTEN;
                           r.command = pdp_cmd_pkg::CMD_LISTEN; ok = 1'b1;
                        end else if (wd == pdp_cmd_pkg::BYTE_UNLISTEN) begin
                           cmd_mode = pdp_cmd_pkg::MODE_IDLE;
                           r.command = pdp_cmd_pkg::CMD_UNLISTEN; ok = 1'b1;
                        end else if (wd == pdp_cmd_pkg::BYTE_UNTALK) begin
                           cmd_mode = pdp_cmd_pkg::MODE_IDLE;
                           r.command = pdp_cmd_pkg::CMD_UNTALK; ok = 1'b1;
                        end
                     end
                  end
                  pdp_cmd_pkg::MODE_TALK: begin
                     if (wd == pdp_cmd_pkg::BYTE_SECONDARY && data_out) begin
                        cmd_mode = pdp_cmd_pkg::MODE_SEC_TALK; ok = 1'b1;
                     end
                  end
                  pdp_cmd_pkg::MODE_LISTEN: begin
                     if (wd == pdp_cmd_pkg::BYTE_SECONDARY && data_out) begin
                        cmd_mode = pdp_cmd_pkg::MODE_SEC_LISTEN; ok = 1'b1;
                     end
                  end
                  pdp_cmd_pkg::MODE_SEC_TALK: begin
                     if (data_out) begin
                        r.command = pdp_cmd_pkg::CMD_SEC_TALK; r.command_byte = wd;
                        ok = 1'b1;
                        cmd_mode = pdp_cmd_pkg::MODE_IDLE;
                     end
                  end
                  pdp_cmd_pkg::MODE_SEC_LISTEN: begin
                     if (data_out) begin
                        r.command = pdp_cmd_pkg::CMD_SEC_LISTEN; r.command_byte = wd;
                        ok = 1'b1;
                        cmd_mode = pdp_cmd_pkg::MODE_IDLE;
                     end
                  end
                  pdp_cmd_pkg::MODE_DATA_OUT: begin
                     if (data_out) begin
                        r.command = pdp_cmd_pkg::CMD_BYTE_OUT; r.command_byte = wd;
                        ok = 1'b1;
                     end
                     cmd_mode = pdp_cmd_pkg::MODE_IDLE;
                  end
                  default: begin
                     cmd_mode = pdp_cmd_pkg::MODE_IDLE;
                     if (wd == pdp_cmd_pkg::BYTE_CMD_MODE) begin
                        if (data_out) begin
                           cmd_mode = pdp_cmd_pkg::MODE_GET_MODE; ok = 1'b1; no_flip = 1'b1;
                        end
                     end else if (wd == pdp_cmd_pkg::BYTE_DATA_OUT) begin
                        cmd_mode = pdp_cmd_pkg::MODE_DATA_OUT; ok = 1'b1;
                     end else if (wd == pdp_cmd_pkg::BYTE_FETCH) begin
                        fetched = w.drive_byte; r.command = pdp_cmd_pkg::CMD_FETCH;
                        ok = 1'b1;
                     end
                  end
               endcase
               // A command that was taken is acknowledged by toggling the ack bit.
               if (ok) begin
                  hs_reg[d] = hs_reg[d] ^ pdp_cmd_pkg::ACK_BIT;
                  r.handshake_write = 1'b1;
                  r.handshake_value = hs_reg[d];
               end
            end
            pdp_cmd_pkg::REG_STATUS: begin
               if (!status_out) r.return_value = {6'd0, st};
            end
            pdp_cmd_pkg::REG_HANDSHAKE: begin
               if (valid_out && !no_flip) begin
                  hs_reg[d] = wd ^ pdp_cmd_pkg::ACK_BIT;
                  r.return_value = hs_reg[d];
                  r.handshake_write = 1'b1;
                  r.handshake_value = hs_reg[d];
               end
               no_flip = 1'b0;
            end
            pdp_cmd_pkg::REG_DATA_DIR: begin
               data_out = (wd != 8'd0);
               r.data_write = 1'b1;
               r.data_value = fetched;
            end
            pdp_cmd_pkg::REG_STATUS_DIR: status_out = (wd[1:0] != 2'd0);
            pdp_cmd_pkg::REG_HS_DIR: begin
               valid_out = ((wd & pdp_cmd_pkg::VALID_DIR_BIT) != 8'd0);
               ack_out   = ((wd & pdp_cmd_pkg::ACK_BIT) != 8'd0);
            end
            default: ;
         endcase
         if (!status_out) begin
            r.status_write = 1'b1;
            r.status_value = st;
         end
      end
      return r;
   endfunction

   task automatic check_field(input string label, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      pdp_cmd_pkg::rsp_type want;
      if (reset) begin
         bus_en     = 1'b1;
         cmd_mode   = pdp_cmd_pkg::MODE_IDLE;
         no_flip    = 1'b0;
         data_out   = 1'b0;
         status_out = 1'b0;
         valid_out  = 1'b0;
         ack_out    = 1'b0;
         drive_up   = '{1'b0, 1'b0};
         hs_reg     = '{8'd0, 8'd0};
         fetched    = 8'd0;
         expected_results.delete();
         fail_count = 0;
         pending_count <= 0;
      end else begin
         if (csr_valid && csr_ready) bus_en = csr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("return_value", want.return_value, rsp_data.return_value);
               check_field("command", 8'(want.command), 8'(rsp_data.command));
               check_field("command_byte", want.command_byte, rsp_data.command_byte);
               check_field("init_request", 8'(want.init_request),
                           8'(rsp_data.init_request));
               check_field("handshake_write", 8'(want.handshake_write),
                           8'(rsp_data.handshake_write));
               check_field("handshake_value", want.handshake_value, rsp_data.handshake_value);
               check_field("data_write", 8'(want.data_write), 8'(rsp_data.data_write));
               check_field("data_value", want.data_value, rsp_data.data_value);
               check_field("status_write", 8'(want.status_write), 8'(rsp_data.status_write));
               check_field("status_value", 8'(want.status_value), 8'(rsp_data.status_value));
               check_field("status_clear_all", 8'(want.status_clear_all),
                           8'(rsp_data.status_clear_all));
            end
         end
         if (req_valid && !req_stall) expected_results.push_back(predict_port_write(req_data));
         pending_count <= expected_results.size();
      end
   end

endmodule

/* dv/parallel_drive_port_command_fsm_tb.sv */
// Top of the testbench for the parallel drive port command block.
// Depends on pdp_cmd_pkg, parallel_drive_port_command_fsm and pdp_cmd_checker.
`timescale 1ns / 1ps

module parallel_drive_port_command_fsm_tb;

   // The offsets the port leaves unused.
   localparam logic [2:0] REG_UNUSED_LO = 3'd6;
   localparam logic [2:0] REG_UNUSED_HI = 3'd7;
   // Drive select values: high addresses the first drive.
   localparam logic SEL_FIRST  = 1'b1;
   localparam logic SEL_SECOND = 1'b0;
   // Sets the extra wait after the last result drains.
   localparam int LATENCY      = 2;
   localparam int RANDOM_ITEMS = 650;
   localparam int PHASES       = 4;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   // Families of well-formed CPU write sequences.
   typedef enum int {
      SEQ_ADDRESS,
      SEQ_RELEASE,
      SEQ_BYTE_OUT,
      SEQ_FETCH,
      SEQ_HANDSHAKE,
      SEQ_STATUS
   } seq_kind_type;

   typedef struct {
      logic [2:0] offset;
      logic       sel;
      logic [7:0] data;
   } port_write_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   pdp_cmd_pkg::req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   pdp_cmd_pkg::rsp_type rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic                 csr_data;
   int                   fail_count;
   int                   pending_count;

   stall_style_type stall_style = STALL_NONE;
   logic [5:0]      stall_tick  = 6'd0;

   int             items_sent = 0;
   int             burst_left = 0;
   logic           cur_sel    = SEL_FIRST;
   port_write_type write_script [$];

   parallel_drive_port_command_fsm i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   pdp_cmd_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The receiver draws a stall style whenever stall_tick wraps to zero. The styles run
   // from never stalling to stalling most of the time, and one of them stalls
   // on a fixed beat so that holds line up with every phase of the pipeline.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_tick  <= 6'd0;
         stall_style <= STALL_NONE;
      end else begin
         stall_tick <= stall_tick + 6'd1;
         if (stall_tick == 6'd0) stall_style <= stall_style_type'($urandom_range(0, 3));
         case (stall_style)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
            default:     rsp_stall <= (stall_tick[2:0] < 3'd3);
         endcase
      end
   end

   // Presents one item and holds it until the block takes it. The sender
   // works in bursts: valid stays high from one item to the next until the
   // burst runs out, then it may drop for a random gap.
   task automatic send_fields(input logic [2:0] off, input logic sel, input logic [7:0] data,
                              input logic ready, input logic [7:0] dbyte, input logic eoi);
      pdp_cmd_pkg::req_type w;
      int                   gap;
      w.reg_offset   = off;
      w.drive_select = sel;
      w.write_data   = data;
      w.drive_ready  = ready;
      w.drive_byte   = dbyte;
      w.drive_eoi    = eoi;
      req_data  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // Now and then a long burst gives a stretch with no idling at all.
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(0, 12);
      end
   endtask

   // Stops sending and waits until every item sent so far has its result.
   // The checker's count is a registered value, so it is let update before it is read.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // Writes bus_enabled; only called while the block is idle.
   task automatic set_bus_enable(input logic en);
      csr_data  <= en;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_write(input logic [2:0] off, input logic sel, input logic [7:0] data);
      port_write_type pw;
      pw.offset = off;
      pw.sel    = sel;
      pw.data   = data;
      write_script.push_back(pw);
   endtask

   initial begin
      int           phase;
      int           phase_start;
      int           roll;
      int           idx;
      int           n;
      seq_kind_type kind;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With the bus disabled neither drive is brought up, so both writes
      // must come back all zero with no init attempt.
      set_bus_enable(1'b0);
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_FIRST, pdp_cmd_pkg::BYTE_CMD_MODE,
                  1'b1, 8'h00, 1'b1);
      send_fields(pdp_cmd_pkg::REG_STATUS, SEL_SECOND, 8'hff, 1'b1, 8'hff, 1'b0);
      wait_for_results();
      set_bus_enable(1'b1);

      // The first attempt fails because the drive is not ready; the next one
      // succeeds on an unused offset, where besides the init only the status write shows.
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_FIRST, 8'h00, 1'b0, 8'h00, 1'b0);
      send_fields(REG_UNUSED_HI, SEL_FIRST, 8'hff, 1'b1, 8'h00, 1'b1);
      send_fields(REG_UNUSED_LO, SEL_FIRST, 8'h00, 1'b1, 8'hff, 1'b0);
      // Turn the data lines and the valid and ack lines to output.
      send_fields(pdp_cmd_pkg::REG_DATA_DIR, SEL_FIRST, 8'hff, 1'b1, 8'h00, 1'b0);
      send_fields(pdp_cmd_pkg::REG_HS_DIR, SEL_FIRST, 8'hc0, 1'b1, 8'h00, 1'b0);
      // Fetch a byte, then see it loaded into the data register.
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_FIRST, pdp_cmd_pkg::BYTE_FETCH,
                  1'b1, 8'hff, 1'b0);
      send_fields(pdp_cmd_pkg::REG_DATA_DIR, SEL_FIRST, 8'h01, 1'b1, 8'h00, 1'b0);
      // Command mode sets no-flip, so the handshake write right after it
      // must not toggle anything.
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_FIRST, pdp_cmd_pkg::BYTE_CMD_MODE,
                  1'b1, 8'h00, 1'b0);
      send_fields(pdp_cmd_pkg::REG_HANDSHAKE, SEL_FIRST, 8'h00, 1'b1, 8'h00, 1'b0);
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_FIRST, pdp_cmd_pkg::BYTE_TALK,
                  1'b1, 8'h00, 1'b0);
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_FIRST, pdp_cmd_pkg::BYTE_SECONDARY,
                  1'b1, 8'h00, 1'b0);
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_FIRST, 8'h00, 1'b1, 8'h00, 1'b0);
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_FIRST, pdp_cmd_pkg::BYTE_CMD_MODE,
                  1'b1, 8'h00, 1'b0);
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_FIRST, pdp_cmd_pkg::BYTE_LISTEN,
                  1'b1, 8'h00, 1'b0);
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_FIRST, pdp_cmd_pkg::BYTE_SECONDARY,
                  1'b1, 8'h00, 1'b0);
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_FIRST, 8'hff, 1'b1, 8'h00, 1'b0);
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_FIRST, pdp_cmd_pkg::BYTE_CMD_MODE,
                  1'b1, 8'h00, 1'b0);
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_FIRST, pdp_cmd_pkg::BYTE_UNLISTEN,
                  1'b1, 8'h00, 1'b0);
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_FIRST, pdp_cmd_pkg::BYTE_CMD_MODE,
                  1'b1, 8'h00, 1'b0);
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_FIRST, pdp_cmd_pkg::BYTE_UNTALK,
                  1'b1, 8'h00, 1'b0);
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_FIRST, pdp_cmd_pkg::BYTE_DATA_OUT,
                  1'b1, 8'h00, 1'b0);
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_FIRST, 8'ha5, 1'b1, 8'h00, 1'b0);
      // A byte with no meaning in idle mode, then a plain handshake write.
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_FIRST, 8'h55, 1'b1, 8'h00, 1'b0);
      send_fields(pdp_cmd_pkg::REG_HANDSHAKE, SEL_FIRST, 8'hff, 1'b1, 8'h00, 1'b0);
      // With the status lines driven out, the status read returns zero and
      // no status write is made.
      send_fields(pdp_cmd_pkg::REG_STATUS_DIR, SEL_FIRST, 8'h03, 1'b1, 8'h00, 1'b1);
      send_fields(pdp_cmd_pkg::REG_STATUS, SEL_FIRST, 8'h00, 1'b1, 8'h00, 1'b1);
      send_fields(pdp_cmd_pkg::REG_STATUS_DIR, SEL_FIRST, 8'h00, 1'b1, 8'h00, 1'b0);
      // The second drive comes up on a status read at end of data. With the
      // data lines back to input, data-out mode still falls back to idle.
      send_fields(pdp_cmd_pkg::REG_STATUS, SEL_SECOND, 8'h00, 1'b1, 8'h00, 1'b1);
      send_fields(pdp_cmd_pkg::REG_DATA_DIR, SEL_SECOND, 8'h00, 1'b1, 8'h00, 1'b0);
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_SECOND, pdp_cmd_pkg::BYTE_DATA_OUT,
                  1'b1, 8'h00, 1'b0);
      send_fields(pdp_cmd_pkg::REG_DATA, SEL_SECOND, 8'h12, 1'b1, 8'h00, 1'b0);

      // Random part. Each phase starts from an idle block with a fresh
      // bus_enabled setting; the pause before it lets every result drain.
      for (phase = 0; phase < PHASES; phase++) begin
         wait_for_results();
         set_bus_enable((phase == 1) ? 1'b0 : 1'b1);
         phase_start = items_sent;
         while (items_sent - phase_start < RANDOM_ITEMS / PHASES) begin
            write_script.delete();
            if ($urandom_range(0, 3) == 0) cur_sel = ~cur_sel;
            roll = $urandom_range(0, 9);
            if (roll < 2) begin
               // Noise: loose writes anywhere, to either drive.
               n = $urandom_range(1, 3);
               repeat (n) queue_write(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                                      8'($urandom_range(0, 255)));
            end else begin
               kind = seq_kind_type'($urandom_range(0, 5));
               case (kind)
                  SEQ_ADDRESS: begin
                     if ($urandom_range(0, 3) == 0)
                        queue_write(pdp_cmd_pkg::REG_DATA_DIR, cur_sel,
                                    8'($urandom_range(1, 255)));
                     queue_write(pdp_cmd_pkg::REG_DATA, cur_sel, pdp_cmd_pkg::BYTE_CMD_MODE);
                     if ($urandom_range(0, 3) == 0)
                        queue_write(pdp_cmd_pkg::REG_HANDSHAKE, cur_sel,
                                    8'($urandom_range(0, 255)));
                     queue_write(pdp_cmd_pkg::REG_DATA, cur_sel,
                                 $urandom_range(0, 1) ? pdp_cmd_pkg::BYTE_TALK
                                                      : pdp_cmd_pkg::BYTE_LISTEN);
                     queue_write(pdp_cmd_pkg::REG_DATA, cur_sel, pdp_cmd_pkg::BYTE_SECONDARY);
                     queue_write(pdp_cmd_pkg::REG_DATA, cur_sel, 8'($urandom_range(0, 255)));
                  end
                  SEQ_RELEASE: begin
                     queue_write(pdp_cmd_pkg::REG_DATA, cur_sel, pdp_cmd_pkg::BYTE_CMD_MODE);
                     queue_write(pdp_cmd_pkg::REG_DATA, cur_sel,
                                 $urandom_range(0, 1) ? pdp_cmd_pkg::BYTE_UNLISTEN
                                                      : pdp_cmd_pkg::BYTE_UNTALK);
                  end
                  SEQ_BYTE_OUT: begin
                     queue_write(pdp_cmd_pkg::REG_DATA, cur_sel, pdp_cmd_pkg::BYTE_DATA_OUT);
                     queue_write(pdp_cmd_pkg::REG_DATA, cur_sel, 8'($urandom_range(0, 255)));
                  end
                  SEQ_FETCH: begin
                     queue_write(pdp_cmd_pkg::REG_DATA, cur_sel, pdp_cmd_pkg::BYTE_FETCH);
                     queue_write(pdp_cmd_pkg::REG_DATA_DIR, cur_sel,
                                 ($urandom_range(0, 5) == 0) ? 8'd0
                                                             : 8'($urandom_range(1, 255)));
                  end
                  SEQ_HANDSHAKE: begin
                     queue_write(pdp_cmd_pkg::REG_HS_DIR, cur_sel, 8'($urandom_range(0, 255)));
                     queue_write(pdp_cmd_pkg::REG_HANDSHAKE, cur_sel,
                                 8'($urandom_range(0, 255)));
                  end
                  default: begin
                     // Mostly leave the status lines as inputs so that the
                     // trailing status write keeps showing up.
                     queue_write(pdp_cmd_pkg::REG_STATUS_DIR, cur_sel,
                                 ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                             : 8'd0);
                     queue_write(pdp_cmd_pkg::REG_STATUS, cur_sel, 8'($urandom_range(0, 255)));
                  end
               endcase
               // Broken sequences: cut short, or one write replaced.
               if (roll < 4) begin
                  if ($urandom_range(0, 1) == 0) begin
                     n = $urandom_range(1, write_script.size() - 1);
                     repeat (n) void'(write_script.pop_back());
                  end else begin
                     idx = $urandom_range(0, write_script.size() - 1);
                     write_script[idx].offset = 3'($urandom_range(0, 7));
                     write_script[idx].data   = 8'($urandom_range(0, 255));
                  end
               end
            end
            foreach (write_script[i])
               send_fields(write_script[i].offset, write_script[i].sel, write_script[i].data,
                           $urandom_range(0, 7) != 0, 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)));
         end
      end

      wait_for_results();
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
